// ----- rtl/fsbm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsbm_pkg
// shared types and constants of the full search block matching estimator
// ----------------------------------------------------------------------------
package fsbm_pkg;

	// parameter defaults
	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_BLOCK_SIZE = 1;
	localparam int DEF_MAX_SEARCH = 8;

	// field widths
	localparam int POS_W      = 6;
	localparam int PIX_W      = 8;
	localparam int KIND_W     = 2;
	localparam int SHIFT_W    = 4;
	localparam int COST_W     = 22;
	localparam int FRAME_W    = 7;
	localparam int RANGE_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// signed coordinate width, covers origin plus block plus shift both ways
	localparam int COORD_W = 9;

	// register values after reset
	localparam logic [FRAME_W-1:0] RESET_FRAME_WIDTH  = 7'd64;
	localparam logic [FRAME_W-1:0] RESET_FRAME_HEIGHT = 7'd64;
	localparam logic [RANGE_W-1:0] RESET_SEARCH_RANGE = 4'd5;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD_REF = 2'd0,
		KIND_LOAD_CUR = 2'd1,
		KIND_ESTIMATE = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_SEARCH_RANGE = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_ref;
		logic load_cur;
		logic capture;
		logic step;
		logic first;
		logic last;
		logic publish;
	} dp_cmd_t;

	typedef struct packed {
		logic range_empty;
		logic pipe_empty;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/full_search_block_matching.sv -----
// estimate request: scans shifts -R..R-1 in x and y over all BLOCK_SIZE^2 block pixels,
// then drains and publishes; out_valid rises once the result is registered, after any
// wait on out_ready for the previous result; the next request can be taken as it rises
// one estimate in flight, one block pixel per cycle through each frame store read port
// R=0 skips the scan and publishes with found low; an empty frame still scans all shifts
// reset: config back to 64x64, range 5; frame stores are not cleared
`default_nettype none
// ----------------------------------------------------------------------------
// full_search_block_matching
// full search ssd block matching motion estimator, top level
// ----------------------------------------------------------------------------
module full_search_block_matching #(
	parameter int MAX_WIDTH  = fsbm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = fsbm_pkg::DEF_MAX_HEIGHT,
	parameter int BLOCK_SIZE = fsbm_pkg::DEF_BLOCK_SIZE,
	parameter int MAX_SEARCH = fsbm_pkg::DEF_MAX_SEARCH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [fsbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fsbm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [fsbm_pkg::KIND_W-1:0]      kind,
	input  wire logic [fsbm_pkg::POS_W-1:0]       pos_x,
	input  wire logic [fsbm_pkg::POS_W-1:0]       pos_y,
	input  wire logic [fsbm_pkg::PIX_W-1:0]       pixel,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [fsbm_pkg::SHIFT_W-1:0]   shift_x,
	output logic signed [fsbm_pkg::SHIFT_W-1:0]   shift_y,
	output logic [fsbm_pkg::COST_W-1:0]           best_cost,
	output logic                                  found
);

	import fsbm_pkg::*;

	localparam int SHW = $clog2(MAX_SEARCH) + 1;
	localparam int BW  = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

	dp_cmd_t cmd;
	dp_status_t status;
	logic [SHW-1:0] r_eff;
	logic signed [SHW-1:0] sx, sy;
	logic [BW-1:0] bi, bj;

	// config writes are taken at any time
	assign cfg_ready = 1'b1;

	fsbm_ctrl #(
		.BLOCK_SIZE (BLOCK_SIZE),
		.MAX_SEARCH (MAX_SEARCH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.r_eff     (r_eff),
		.status    (status),
		.cmd       (cmd),
		.sx        (sx),
		.sy        (sy),
		.bi        (bi),
		.bj        (bj)
	);

	fsbm_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.BLOCK_SIZE (BLOCK_SIZE),
		.MAX_SEARCH (MAX_SEARCH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pixel     (pixel),
		.cmd       (cmd),
		.sx        (sx),
		.sy        (sy),
		.bi        (bi),
		.bj        (bj),
		.r_eff     (r_eff),
		.status    (status),
		.shift_x   (shift_x),
		.shift_y   (shift_y),
		.best_cost (best_cost),
		.found     (found)
	);

endmodule
`default_nettype wire

// ----- rtl/fsbm_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsbm_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module fsbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ----- rtl/fsbm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsbm_ctrl
// request handshake, scan sequencer over shifts and block pixels, result valid
// ----------------------------------------------------------------------------
module fsbm_ctrl #(
	parameter int BLOCK_SIZE = fsbm_pkg::DEF_BLOCK_SIZE,
	parameter int MAX_SEARCH = fsbm_pkg::DEF_MAX_SEARCH,
	localparam int SHW = $clog2(MAX_SEARCH) + 1,
	localparam int BW  = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [fsbm_pkg::KIND_W-1:0]  kind,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	input  wire logic [SHW-1:0]               r_eff,
	input  wire fsbm_pkg::dp_status_t         status,
	output fsbm_pkg::dp_cmd_t                 cmd,
	output logic signed [SHW-1:0]             sx,
	output logic signed [SHW-1:0]             sy,
	output logic [BW-1:0]                     bi,
	output logic [BW-1:0]                     bj
);

	import fsbm_pkg::*;

	localparam logic [BW-1:0] LAST_B = BW'(BLOCK_SIZE - 1);

	state_t state_q, state_d;
	logic signed [SHW-1:0] sx_q, sy_q;
	logic [BW-1:0] bi_q, bj_q;
	logic out_valid_q;
	logic accept, pix_last, cand_last, can_publish;
	logic signed [SHW-1:0] r_start, r_last;

	assign r_start = $signed(SHW'(0) - r_eff);
	assign r_last  = $signed(r_eff - SHW'(1));

	assign accept      = in_valid && in_ready;
	assign pix_last    = (bi_q == LAST_B) && (bj_q == LAST_B);
	assign cand_last   = (sx_q == r_last) && (sy_q == r_last);
	assign can_publish = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && kind == KIND_ESTIMATE) begin
					state_d = status.range_empty ? ST_DRAIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (pix_last && cand_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (status.pipe_empty) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (can_publish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd          = '0;
		cmd.load_ref = accept && (kind == KIND_LOAD_REF);
		cmd.load_cur = accept && (kind == KIND_LOAD_CUR);
		cmd.capture  = accept && (kind == KIND_ESTIMATE);
		cmd.step     = (state_q == ST_SCAN);
		cmd.first    = (bi_q == '0) && (bj_q == '0);
		cmd.last     = pix_last;
		cmd.publish  = (state_q == ST_FINISH) && can_publish;
	end

	assign out_valid = out_valid_q;
	assign sx = sx_q;
	assign sy = sy_q;
	assign bi = bi_q;
	assign bj = bj_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			sx_q        <= '0;
			sy_q        <= '0;
			bi_q        <= '0;
			bj_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.capture) begin
				sx_q <= r_start;
				sy_q <= r_start;
				bi_q <= '0;
				bj_q <= '0;
			end else if (state_q == ST_SCAN) begin
				// block pixels inner, then sy, then sx
				if (bj_q == LAST_B) begin
					bj_q <= '0;
					if (bi_q == LAST_B) begin
						bi_q <= '0;
						if (sy_q == r_last) begin
							sy_q <= r_start;
							sx_q <= sx_q + SHW'(1);
						end else begin
							sy_q <= sy_q + SHW'(1);
						end
					end else begin
						bi_q <= bi_q + BW'(1);
					end
				end else begin
					bj_q <= bj_q + BW'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/fsbm_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsbm_dp
// config registers, frame stores, squared difference pipeline, best tracking
// ----------------------------------------------------------------------------
module fsbm_dp #(
	parameter int MAX_WIDTH  = fsbm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = fsbm_pkg::DEF_MAX_HEIGHT,
	parameter int BLOCK_SIZE = fsbm_pkg::DEF_BLOCK_SIZE,
	parameter int MAX_SEARCH = fsbm_pkg::DEF_MAX_SEARCH,
	localparam int SHW = $clog2(MAX_SEARCH) + 1,
	localparam int BW  = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	input  wire logic [fsbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fsbm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [fsbm_pkg::POS_W-1:0]       pos_x,
	input  wire logic [fsbm_pkg::POS_W-1:0]       pos_y,
	input  wire logic [fsbm_pkg::PIX_W-1:0]       pixel,
	input  wire fsbm_pkg::dp_cmd_t                cmd,
	input  wire logic signed [SHW-1:0]            sx,
	input  wire logic signed [SHW-1:0]            sy,
	input  wire logic [BW-1:0]                    bi,
	input  wire logic [BW-1:0]                    bj,
	output logic [SHW-1:0]                        r_eff,
	output fsbm_pkg::dp_status_t                  status,
	output logic signed [fsbm_pkg::SHIFT_W-1:0]   shift_x,
	output logic signed [fsbm_pkg::SHIFT_W-1:0]   shift_y,
	output logic [fsbm_pkg::COST_W-1:0]           best_cost,
	output logic                                  found
);

	import fsbm_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int SUM_W = $clog2(BLOCK_SIZE * BLOCK_SIZE * 65025 + 1);

	// config
	logic [FRAME_W-1:0] fw_q, fh_q, w_eff, h_eff;
	logic [RANGE_W-1:0] sr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= RESET_FRAME_WIDTH;
			fh_q <= RESET_FRAME_HEIGHT;
			sr_q <= RESET_SEARCH_RANGE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  fw_q <= cfg_data[FRAME_W-1:0];
				REG_FRAME_HEIGHT: fh_q <= cfg_data[FRAME_W-1:0];
				REG_SEARCH_RANGE: sr_q <= cfg_data[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	assign w_eff = (int'(fw_q) > MAX_WIDTH)  ? FRAME_W'(MAX_WIDTH)  : fw_q;
	assign h_eff = (int'(fh_q) > MAX_HEIGHT) ? FRAME_W'(MAX_HEIGHT) : fh_q;
	assign r_eff = (int'(sr_q) > MAX_SEARCH) ? SHW'(MAX_SEARCH) : SHW'(sr_q);
	assign status.range_empty = (r_eff == '0);

	// loads
	logic load_in;
	logic [AW-1:0] wr_addr;

	assign load_in = (int'(pos_x) < MAX_WIDTH) && (int'(pos_y) < MAX_HEIGHT);
	assign wr_addr = AW'(32'(pos_y) * MAX_WIDTH + 32'(pos_x));

	// block origin
	logic [POS_W-1:0] ox_q, oy_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ox_q <= pos_x;
			oy_q <= pos_y;
		end
	end

	// stage 0: coordinates, frame checks, store addresses
	logic signed [COORD_W-1:0] bx, by, rx, ry, w_s, h_s;
	logic ok_s0;
	logic [AW-1:0] cur_addr, ref_addr;

	assign bx  = $signed(COORD_W'(ox_q) + COORD_W'(bi));
	assign by  = $signed(COORD_W'(oy_q) + COORD_W'(bj));
	assign rx  = bx + COORD_W'(sx);
	assign ry  = by + COORD_W'(sy);
	assign w_s = $signed(COORD_W'(w_eff));
	assign h_s = $signed(COORD_W'(h_eff));

	assign ok_s0 = (bx < w_s) && (by < h_s) &&
		(rx >= 0) && (rx < w_s) && (ry >= 0) && (ry < h_s);

	// only meaningful when inside the frame
	assign cur_addr = AW'(32'(by[FRAME_W-1:0]) * MAX_WIDTH + 32'(bx[FRAME_W-1:0]));
	assign ref_addr = AW'(32'(ry[FRAME_W-1:0]) * MAX_WIDTH + 32'(rx[FRAME_W-1:0]));

	logic [PIX_W-1:0] cur_pix, ref_pix;

	fsbm_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_ref_store (
		.clk     (clk),
		.wr_en   (cmd.load_ref && load_in),
		.wr_addr (wr_addr),
		.wr_data (pixel),
		.rd_addr (ref_addr),
		.rd_data (ref_pix)
	);

	fsbm_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_cur_store (
		.clk     (clk),
		.wr_en   (cmd.load_cur && load_in),
		.wr_addr (wr_addr),
		.wr_data (pixel),
		.rd_addr (cur_addr),
		.rd_data (cur_pix)
	);

	// stage 1: store data arrives, square the difference
	logic vld_s1, first_s1, last_s1, ok_s1;
	logic signed [SHW-1:0] sx_s1, sy_s1;
	logic signed [PIX_W:0] diff;
	logic signed [2*PIX_W+1:0] prod;

	assign diff = $signed({1'b0, cur_pix}) - $signed({1'b0, ref_pix});
	assign prod = diff * diff;

	// stage 2: accumulate over the block, compare at the last pixel
	logic vld_s2, first_s2, last_s2, ok_s2;
	logic signed [SHW-1:0] sx_s2, sy_s2;
	logic [2*PIX_W-1:0] sq_s2;
	logic [SUM_W-1:0] acc_q, cand_sum, best_q;
	logic okacc_q, cand_ok, found_q;
	logic signed [SHW-1:0] best_x_q, best_y_q;

	assign cand_sum = (first_s2 ? '0 : acc_q) + SUM_W'(sq_s2);
	assign cand_ok  = ok_s2 && (first_s2 || okacc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.step;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		ok_s1    <= ok_s0;
		sx_s1    <= sx;
		sy_s1    <= sy;

		first_s2 <= first_s1;
		last_s2  <= last_s1;
		ok_s2    <= ok_s1;
		sx_s2    <= sx_s1;
		sy_s2    <= sy_s1;
		sq_s2    <= prod[2*PIX_W-1:0];

		if (vld_s2) begin
			acc_q   <= cand_sum;
			okacc_q <= cand_ok;
		end

		if (cmd.capture) begin
			found_q  <= 1'b0;
			best_q   <= '0;
			best_x_q <= '0;
			best_y_q <= '0;
		end else if (vld_s2 && last_s2 && cand_ok && (!found_q || cand_sum <= best_q)) begin
			// ties go to the later shift
			found_q  <= 1'b1;
			best_q   <= cand_sum;
			best_x_q <= sx_s2;
			best_y_q <= sy_s2;
		end

		// output register
		if (cmd.publish) begin
			shift_x   <= SHIFT_W'(best_x_q);
			shift_y   <= SHIFT_W'(best_y_q);
			best_cost <= COST_W'(best_q);
			found     <= found_q;
		end
	end

	assign status.pipe_empty = !vld_s1 && !vld_s2;

endmodule
`default_nettype wire
